// File: sv/assert_macros.svh
// Assertion macros used by the RTL of the point mover.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: property failed");
// Check that an expression is never true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: sv/pmi_pkg.sv
// Shared types and constants of the point mover.
package pmi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int STEP_BITS      = 16;
	localparam int POS_BITS       = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_START_X    = 3'd0,
		REG_START_Y    = 3'd1,
		REG_TARGET_X   = 3'd2,
		REG_TARGET_Y   = 3'd3,
		REG_STEP_TOTAL = 3'd4,
		REG_RETURN     = 3'd5,
		REG_HOLD_MODE  = 3'd6
	} pmi_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT_X,
		ST_WAIT_Y,
		ST_FINISH
	} pmi_state_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_MUL,
		U_DIV
	} pmi_unit_state_t;

endpackage

// File: sv/pmi_if.sv
// Handshake channels of the point mover: tick in, result out, register writes.
interface pmi_tick_if;
	logic valid;
	logic ready;
	logic point_enabled;

	modport source (output valid, output point_enabled, input ready);
	modport sink (input valid, input point_enabled, output ready);
endinterface

interface pmi_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pmi_pkg::POS_BITS-1:0]  pos_x;
	logic signed [pmi_pkg::POS_BITS-1:0]  pos_y;
	logic                                 move_done;
	logic                                 keep_waiting;

	modport source (output valid, output pos_x, output pos_y, output move_done,
		output keep_waiting, input ready);
	modport sink (input valid, input pos_x, input pos_y, input move_done,
		input keep_waiting, output ready);
endinterface

interface pmi_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [pmi_pkg::CFG_INDEX_BITS-1:0]   index;
	logic [pmi_pkg::CFG_DATA_BITS-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/pmi_interp_unit.sv
// Shared interpolation unit: one multiply, then a restoring divide one bit a cycle.
module pmi_interp_unit #(
	parameter int COORD_BITS = pmi_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [COORD_BITS-1:0]         s,
	input  logic signed [COORD_BITS-1:0]         t,
	input  logic [pmi_pkg::STEP_BITS-1:0]        n,
	input  logic [pmi_pkg::STEP_BITS-1:0]        d,
	output logic                                 done,
	output logic signed [COORD_BITS-1:0]         result
);

	localparam int SB = pmi_pkg::STEP_BITS;
	localparam int DW = COORD_BITS + 1;   // span width
	localparam int QW = COORD_BITS + 1;   // quotient never exceeds the span
	localparam int PW = DW + SB;          // product width
	localparam int CW = $clog2(QW);

	pmi_pkg::pmi_unit_state_t state_q, state_d;

	logic signed [COORD_BITS-1:0] s_q;
	logic [SB-1:0]                n_q;
	logic [SB-1:0]                d_q;
	logic [DW-1:0]                mag_q;
	logic                         neg_q;
	logic [SB-1:0]                rem_q;
	logic [QW-1:0]                quo_q;
	logic [CW-1:0]                cnt_q;
	logic                         done_q;
	logic signed [COORD_BITS-1:0] res_q;

	logic signed [DW-1:0]         diff;
	logic [DW-1:0]                mag;
	logic [PW-1:0]                prod;
	logic [SB:0]                  trial;
	logic                         q_bit;
	logic [SB-1:0]                rem_nxt;
	logic [QW-1:0]                quo_nxt;
	logic signed [COORD_BITS-1:0] q_lo;
	logic signed [COORD_BITS-1:0] res_nxt;

	logic ld_op, ld_div, step_div, fin;

	assign diff = DW'(t) - DW'(s);
	assign mag  = diff[DW-1] ? -diff : diff;
	assign prod = PW'(mag_q) * PW'(n_q);

	// one restoring step: bring down the next dividend bit, try the subtract
	assign trial   = {rem_q, quo_q[QW-1]} - {1'b0, d_q};
	assign q_bit   = ~trial[SB];
	assign rem_nxt = q_bit ? trial[SB-1:0] : {rem_q[SB-2:0], quo_q[QW-1]};
	assign quo_nxt = {quo_q[QW-2:0], q_bit};
	assign q_lo    = $signed(quo_nxt[COORD_BITS-1:0]);
	assign res_nxt = neg_q ? (s_q - q_lo) : (s_q + q_lo);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmi_pkg::U_IDLE: begin
				if (start) begin
					state_d = pmi_pkg::U_MUL;
				end
			end
			pmi_pkg::U_MUL: begin
				state_d = pmi_pkg::U_DIV;
			end
			pmi_pkg::U_DIV: begin
				if (cnt_q == '0) begin
					state_d = pmi_pkg::U_IDLE;
				end
			end
			default: begin
				state_d = pmi_pkg::U_IDLE;
			end
		endcase
	end

	always_comb begin
		ld_op    = 1'b0;
		ld_div   = 1'b0;
		step_div = 1'b0;
		fin      = 1'b0;
		unique case (state_q)
			pmi_pkg::U_IDLE: ld_op  = start;
			pmi_pkg::U_MUL:  ld_div = 1'b1;
			pmi_pkg::U_DIV: begin
				step_div = 1'b1;
				fin      = (cnt_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmi_pkg::U_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_op) begin
			s_q   <= s;
			n_q   <= n;
			d_q   <= d;
			mag_q <= mag;
			neg_q <= diff[DW-1];
		end
		if (ld_div) begin
			// high part is below the divisor since the step never passes the total
			rem_q <= prod[PW-1:QW];
			quo_q <= prod[QW-1:0];
			cnt_q <= CW'(QW - 1);
		end
		if (step_div) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
			cnt_q <= cnt_q - 1'b1;
		end
		if (fin) begin
			res_q <= res_nxt;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: sv/point_move_interpolator.sv
// Point mover top level: registers, tick sequencer and result register.
//
// Usage: write the seven registers through cfg (index 0..6: start x/y,
// target x/y, step total, return option, hold mode). Any write to 0..6 re-arms
// the move at the start point. Each word on tick is one frame tick with
// its enable bit; each tick yields exactly one word on result with the
// position after the tick, the done flag and the keep-waiting answer.
// A tick that moves the point runs two interpolations (x, then y) on one
// shared multiply and bit-serial divide unit. A tick that only jumps to
// the target, ends the return or does not move goes straight to the
// finishing step. tick.ready is high only while the sequencer is idle;
// once a result is loaded the sequencer returns to idle, so the next tick
// can be taken even if that result still waits in the output register.
// When the receiver stalls, the sequencer holds in its finishing step
// until the output register frees up. Reset clears the configuration and
// move registers to zero, empties the output register and places the
// point at the origin.
`include "assert_macros.svh"

module point_move_interpolator #(
	parameter int COORD_BITS = pmi_pkg::COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	pmi_tick_if.sink            tick,
	pmi_result_if.source        result,
	pmi_cfg_if.sink             cfg
);

	localparam int SB = pmi_pkg::STEP_BITS;
	localparam int PB = pmi_pkg::POS_BITS;
	localparam int XW = (COORD_BITS > pmi_pkg::CFG_DATA_BITS) ? COORD_BITS
		: pmi_pkg::CFG_DATA_BITS;

	// configuration registers
	logic signed [COORD_BITS-1:0] start_x_q, start_y_q, target_x_q, target_y_q;
	logic [SB-1:0]                step_total_q;
	logic                         return_trip_q, hold_mode_q;

	// move state
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [SB-1:0]                step_count_q;
	logic                         returning_q, finished_q, return_pending_q;

	// result register
	logic                         out_valid_q;
	logic signed [PB-1:0]         pos_x_q, pos_y_q;
	logic                         move_done_q, keep_waiting_q;

	pmi_pkg::pmi_state_t state_q, state_d;

	// next register values on a write
	logic [XW-1:0]                cfg_wide;
	logic signed [COORD_BITS-1:0] cfg_coord;
	pmi_pkg::pmi_reg_t            cfg_idx;
	logic                         cfg_known;
	logic signed [COORD_BITS-1:0] nx_start_x, nx_start_y, nx_target_x, nx_target_y;
	logic [SB-1:0]                nx_step_total;
	logic                         nx_return_trip, nx_hold_mode;

	logic tick_fire, cfg_fire, fin_fire, out_free;
	logic at_target, at_start, complete, active;
	logic br_jump, br_end, need_interp;
	logic [SB-1:0] step_nxt;

	logic                         tick_ready, cfg_ready;
	logic                         unit_start, unit_done;
	logic [SB-1:0]                unit_n;
	logic signed [COORD_BITS-1:0] unit_s, unit_t, unit_res;

	// keep only the low COORD_BITS of the zero-extended 16-bit word
	assign cfg_wide  = XW'(cfg.data);
	assign cfg_coord = $signed(cfg_wide[COORD_BITS-1:0]);
	assign cfg_idx   = pmi_pkg::pmi_reg_t'(cfg.index);

	always_comb begin
		nx_start_x     = start_x_q;
		nx_start_y     = start_y_q;
		nx_target_x    = target_x_q;
		nx_target_y    = target_y_q;
		nx_step_total  = step_total_q;
		nx_return_trip = return_trip_q;
		nx_hold_mode   = hold_mode_q;
		cfg_known      = 1'b1;
		unique case (cfg_idx)
			pmi_pkg::REG_START_X:    nx_start_x     = cfg_coord;
			pmi_pkg::REG_START_Y:    nx_start_y     = cfg_coord;
			pmi_pkg::REG_TARGET_X:   nx_target_x    = cfg_coord;
			pmi_pkg::REG_TARGET_Y:   nx_target_y    = cfg_coord;
			pmi_pkg::REG_STEP_TOTAL: nx_step_total  = cfg.data;
			pmi_pkg::REG_RETURN:     nx_return_trip = cfg.data[0];
			pmi_pkg::REG_HOLD_MODE:  nx_hold_mode   = cfg.data[0];
			default:                 cfg_known      = 1'b0;
		endcase
	end

	// completion test; the same test gates motion before the step
	assign at_target = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
	assign at_start  = (cur_x_q == start_x_q) && (cur_y_q == start_y_q);
	assign complete  = finished_q || (!return_pending_q && at_target)
		|| (return_pending_q && returning_q && at_start);

	assign active      = tick.point_enabled && !complete;
	assign br_jump     = !returning_q && (step_count_q >= step_total_q);
	assign br_end      = returning_q && (step_count_q <= SB'(1));
	assign need_interp = active && !br_jump && !br_end;
	assign step_nxt    = returning_q ? (step_count_q - 1'b1) : (step_count_q + 1'b1);

	assign out_free  = !out_valid_q || result.ready;
	assign tick_fire = tick.valid && tick_ready;
	assign cfg_fire  = cfg.valid && cfg_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmi_pkg::ST_IDLE: begin
				if (tick_fire) begin
					state_d = need_interp ? pmi_pkg::ST_WAIT_X : pmi_pkg::ST_FINISH;
				end
			end
			pmi_pkg::ST_WAIT_X: begin
				if (unit_done) begin
					state_d = pmi_pkg::ST_WAIT_Y;
				end
			end
			pmi_pkg::ST_WAIT_Y: begin
				if (unit_done) begin
					state_d = pmi_pkg::ST_FINISH;
				end
			end
			pmi_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = pmi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pmi_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		tick_ready = 1'b0;
		cfg_ready  = 1'b0;
		unit_start = 1'b0;
		fin_fire   = 1'b0;
		unit_n     = step_count_q;
		unit_s     = start_y_q;
		unit_t     = target_y_q;
		unique case (state_q)
			pmi_pkg::ST_IDLE: begin
				// a register write takes the cycle ahead of a tick
				cfg_ready  = 1'b1;
				tick_ready = !cfg.valid;
				unit_start = tick.valid && tick_ready && need_interp;
				unit_n     = step_nxt;
				unit_s     = start_x_q;
				unit_t     = target_x_q;
			end
			pmi_pkg::ST_WAIT_X: unit_start = unit_done;
			pmi_pkg::ST_WAIT_Y: ;
			pmi_pkg::ST_FINISH: fin_fire = out_free;
			default: ;
		endcase
	end

	pmi_interp_unit #(
		.COORD_BITS (COORD_BITS)
	) u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.s      (unit_s),
		.t      (unit_t),
		.n      (unit_n),
		.d      (step_total_q),
		.done   (unit_done),
		.result (unit_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= pmi_pkg::ST_IDLE;
			start_x_q        <= '0;
			start_y_q        <= '0;
			target_x_q       <= '0;
			target_y_q       <= '0;
			step_total_q     <= '0;
			return_trip_q    <= 1'b0;
			hold_mode_q      <= 1'b0;
			cur_x_q          <= '0;
			cur_y_q          <= '0;
			step_count_q     <= '0;
			returning_q      <= 1'b0;
			finished_q       <= 1'b0;
			return_pending_q <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				start_x_q     <= nx_start_x;
				start_y_q     <= nx_start_y;
				target_x_q    <= nx_target_x;
				target_y_q    <= nx_target_y;
				step_total_q  <= nx_step_total;
				return_trip_q <= nx_return_trip;
				hold_mode_q   <= nx_hold_mode;
				if (cfg_known) begin
					// re-arm at the (possibly new) start
					cur_x_q          <= nx_start_x;
					cur_y_q          <= nx_start_y;
					step_count_q     <= '0;
					returning_q      <= 1'b0;
					finished_q       <= 1'b0;
					return_pending_q <= nx_return_trip;
				end
			end else if (tick_fire && active) begin
				if (br_jump) begin
					// outbound count used up: land on the target, turn around
					cur_x_q     <= target_x_q;
					cur_y_q     <= target_y_q;
					returning_q <= 1'b1;
				end else if (br_end) begin
					// last return step: snap to the start and finish
					step_count_q <= '0;
					cur_x_q      <= start_x_q;
					cur_y_q      <= start_y_q;
					finished_q   <= 1'b1;
				end else begin
					step_count_q <= step_nxt;
				end
			end
			if (unit_done && state_q == pmi_pkg::ST_WAIT_X) begin
				cur_x_q <= unit_res;
			end
			if (unit_done && state_q == pmi_pkg::ST_WAIT_Y) begin
				cur_y_q <= unit_res;
			end
			if (fin_fire && complete) begin
				finished_q       <= 1'b1;
				returning_q      <= 1'b0;
				return_pending_q <= 1'b0;
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// load the result word once the output register is free
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			pos_x_q        <= PB'(cur_x_q);
			pos_y_q        <= PB'(cur_y_q);
			move_done_q    <= complete;
			keep_waiting_q <= !complete && hold_mode_q;
		end
	end

	assign tick.ready          = tick_ready;
	assign cfg.ready           = cfg_ready;
	assign result.valid        = out_valid_q;
	assign result.pos_x        = pos_x_q;
	assign result.pos_y        = pos_y_q;
	assign result.move_done    = move_done_q;
	assign result.keep_waiting = keep_waiting_q;

	`ASSERT_PROP(a_done_no_wait, clk, arst_n, result.valid && result.move_done |-> !result.keep_waiting)
	`ASSERT_PROP(a_step_bound, clk, arst_n, step_count_q <= step_total_q)
	`ASSERT_PROP(a_idle_flags, clk, arst_n, finished_q && state_q == pmi_pkg::ST_IDLE |-> !returning_q && !return_pending_q)
	`ASSERT_NEVER(a_unit_seq, clk, arst_n, unit_done && (state_q == pmi_pkg::ST_IDLE || state_q == pmi_pkg::ST_FINISH))
	`ASSERT_PROP(a_tick_leaves_idle, clk, arst_n, tick.valid && tick.ready |=> state_q != pmi_pkg::ST_IDLE)

endmodule
